@@ rtl/qlc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlc_pkg
// Widths, types and constants shared by the quad line clipper modules.
// ----------------------------------------------------------------------------
package qlc_pkg;

    localparam int CW         = 16;
    localparam int DW         = CW + 1;
    localparam int MW         = 2 * DW;
    localparam int PW         = MW + 1;
    localparam int TW         = PW + 1;
    localparam int XW         = 2 * TW;
    localparam int NW         = CW + TW + 2;
    localparam int QB         = CW + 1;
    localparam int RW         = NW - QB;
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = (QB + DIV_STEPS - 1) / DIV_STEPS;
    localparam int EDGES      = 4;
    localparam int CI_W       = $clog2(EDGES);
    localparam int COORDS     = 4;
    localparam int IDX_W      = 4;
    localparam int REG_COUNT  = 2 * EDGES;

    localparam logic signed [CW-1:0] CORNER_LO = CW'(0);
    localparam logic signed [CW-1:0] CORNER_HI = CW'(4095);
    localparam logic [QB-1:0]        QUO_MAX   = QB'(1) << (CW - 1);

    typedef logic signed [CW-1:0] t_coord;
    typedef logic signed [DW-1:0] t_diff;
    typedef logic signed [TW-1:0] t_frac;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_point;

    typedef struct packed {
        t_coord sx;
        t_coord sy;
        t_diff  dx;
        t_diff  dy;
    } t_seg;

    typedef struct packed {
        t_frac p;
        t_frac q;
        logic  ent;
    } t_edge_t;

    typedef struct packed {
        t_frac ep;
        t_frac eq;
        t_frac lp;
        t_frac lq;
    } t_acc;

    typedef struct packed {
        logic [RW-1:0] rem;
        logic [QB-1:0] nlo;
        logic [QB-1:0] quo;
        logic [TW-1:0] q;
        logic          neg;
    } t_lane;

endpackage

@@ rtl/quad_line_clipper_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quad_line_clipper_core
// Cyrus-Beck clip of one segment against a convex quadrilateral held in
// eight corner registers, with exact rational edge parameters.
// ----------------------------------------------------------------------------
// The core takes one segment per clock unless stalled. Its path has 3 stages
// of edge setup, 2 per edge for the t_enter / t_leave fold, 2 for the reject
// test, 2 for interpolation, 9 divider stages at two quotient bits each, and
// the output register. A stall on the output with a result held freezes the
// whole pipeline and stalls the input. The user writes corner registers via
// the configuration port only while the pipeline is empty; the core does not
// enforce this. The port is always ready and ignores indexes above seven.
// ----------------------------------------------------------------------------
module quad_line_clipper_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic signed [qlc_pkg::CW-1:0]   i_start_x,
    input  logic signed [qlc_pkg::CW-1:0]   i_start_y,
    input  logic signed [qlc_pkg::CW-1:0]   i_end_x,
    input  logic signed [qlc_pkg::CW-1:0]   i_end_y,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_visible,
    output logic signed [qlc_pkg::CW-1:0]   o_clipped_start_x,
    output logic signed [qlc_pkg::CW-1:0]   o_clipped_start_y,
    output logic signed [qlc_pkg::CW-1:0]   o_clipped_end_x,
    output logic signed [qlc_pkg::CW-1:0]   o_clipped_end_y,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [qlc_pkg::IDX_W-1:0]       i_cfg_index,
    input  logic [qlc_pkg::CW-1:0]          i_cfg_data
);

    logic                                  w_adv;
    qlc_pkg::t_point [qlc_pkg::EDGES-1:0]  r_corner;
    qlc_pkg::t_point                       w_start;
    qlc_pkg::t_point                       w_end;

    logic                                  e_valid;
    qlc_pkg::t_seg                         e_seg;
    qlc_pkg::t_edge_t [qlc_pkg::EDGES-1:0] e_edge;

    logic                                  f_valid;
    qlc_pkg::t_seg                         f_seg;
    qlc_pkg::t_acc                         f_acc;
    logic                                  f_vis;

    logic                                  i_valid_l;
    qlc_pkg::t_lane [qlc_pkg::COORDS-1:0]  l_lane;
    logic                                  l_vis;

    logic                                  d_valid;
    qlc_pkg::t_lane [qlc_pkg::COORDS-1:0]  d_lane;
    logic                                  d_vis;

    logic                                  r_out_valid;
    logic                                  r_visible;
    qlc_pkg::t_coord                       r_coord [qlc_pkg::COORDS];
    qlc_pkg::t_coord                       n_coord [qlc_pkg::COORDS];

    assign w_adv       = !r_out_valid || !i_out_stall;
    assign o_in_stall  = !w_adv;
    assign o_cfg_ready = 1'b1;

    assign w_start = '{x: i_start_x, y: i_start_y};
    assign w_end   = '{x: i_end_x,   y: i_end_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner[0] <= '{x: qlc_pkg::CORNER_LO, y: qlc_pkg::CORNER_LO};
            r_corner[1] <= '{x: qlc_pkg::CORNER_HI, y: qlc_pkg::CORNER_LO};
            r_corner[2] <= '{x: qlc_pkg::CORNER_HI, y: qlc_pkg::CORNER_HI};
            r_corner[3] <= '{x: qlc_pkg::CORNER_LO, y: qlc_pkg::CORNER_HI};
        end else if (i_cfg_valid && o_cfg_ready
                     && (i_cfg_index < qlc_pkg::IDX_W'(qlc_pkg::REG_COUNT))) begin
            if (i_cfg_index[0]) begin
                r_corner[i_cfg_index[qlc_pkg::CI_W:1]].y <= i_cfg_data;
            end else begin
                r_corner[i_cfg_index[qlc_pkg::CI_W:1]].x <= i_cfg_data;
            end
        end
    end

    qlc_edge u_edge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_adv),
        .i_valid  (i_in_valid),
        .i_start  (w_start),
        .i_end    (w_end),
        .i_corner (r_corner),
        .o_valid  (e_valid),
        .o_seg    (e_seg),
        .o_edge   (e_edge)
    );

    qlc_fold u_fold (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (e_valid),
        .i_seg   (e_seg),
        .i_edge  (e_edge),
        .o_valid (f_valid),
        .o_seg   (f_seg),
        .o_acc   (f_acc),
        .o_vis   (f_vis)
    );

    qlc_interp u_interp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (f_valid),
        .i_seg   (f_seg),
        .i_acc   (f_acc),
        .i_vis   (f_vis),
        .o_valid (i_valid_l),
        .o_lane  (l_lane),
        .o_vis   (l_vis)
    );

    qlc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (i_valid_l),
        .i_lane  (l_lane),
        .i_vis   (l_vis),
        .o_valid (d_valid),
        .o_lane  (d_lane),
        .o_vis   (d_vis)
    );

    always_comb begin
        for (int c = 0; c < qlc_pkg::COORDS; c++) begin
            if (!d_vis) begin
                n_coord[c] = '0;
            end else if (d_lane[c].neg) begin
                n_coord[c] = qlc_pkg::CW'(qlc_pkg::QB'(0) - d_lane[c].quo);
            end else begin
                n_coord[c] = qlc_pkg::CW'(d_lane[c].quo);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_visible <= d_vis;
            for (int c = 0; c < qlc_pkg::COORDS; c++) begin
                r_coord[c] <= n_coord[c];
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_visible         = r_visible;
    assign o_clipped_start_x = r_coord[0];
    assign o_clipped_start_y = r_coord[1];
    assign o_clipped_end_x   = r_coord[2];
    assign o_clipped_end_y   = r_coord[3];

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_visible) |->
            (o_clipped_start_x == '0) && (o_clipped_start_y == '0)
            && (o_clipped_end_x == '0) && (o_clipped_end_y == '0))
        else $error("rejected segment with nonzero coordinates");

    a_empty_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result present right after reset");

endmodule

@@ rtl/qlc_edge.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlc_edge
// Three-stage edge setup: normals and offsets, products, then the edge
// fraction p/q and its entering or leaving role for every quadrilateral edge.
// ----------------------------------------------------------------------------
module qlc_edge (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_en,
    input  logic                                      i_valid,
    input  qlc_pkg::t_point                           i_start,
    input  qlc_pkg::t_point                           i_end,
    input  qlc_pkg::t_point [qlc_pkg::EDGES-1:0]      i_corner,
    output logic                                      o_valid,
    output qlc_pkg::t_seg                             o_seg,
    output qlc_pkg::t_edge_t [qlc_pkg::EDGES-1:0]     o_edge
);

    logic                          r1_valid;
    qlc_pkg::t_seg                 r1_seg;
    qlc_pkg::t_seg                 n1_seg;
    qlc_pkg::t_diff                r1_ex [qlc_pkg::EDGES];
    qlc_pkg::t_diff                r1_ey [qlc_pkg::EDGES];
    qlc_pkg::t_diff                r1_nx [qlc_pkg::EDGES];
    qlc_pkg::t_diff                r1_ny [qlc_pkg::EDGES];
    qlc_pkg::t_diff                n1_ex [qlc_pkg::EDGES];
    qlc_pkg::t_diff                n1_ey [qlc_pkg::EDGES];
    qlc_pkg::t_diff                n1_nx [qlc_pkg::EDGES];
    qlc_pkg::t_diff                n1_ny [qlc_pkg::EDGES];

    logic                          r2_valid;
    qlc_pkg::t_seg                 r2_seg;
    logic signed [qlc_pkg::MW-1:0] r2_a [qlc_pkg::EDGES];
    logic signed [qlc_pkg::MW-1:0] r2_b [qlc_pkg::EDGES];
    logic signed [qlc_pkg::MW-1:0] r2_c [qlc_pkg::EDGES];
    logic signed [qlc_pkg::MW-1:0] r2_d [qlc_pkg::EDGES];

    logic                          r3_valid;
    qlc_pkg::t_seg                 r3_seg;
    qlc_pkg::t_edge_t [qlc_pkg::EDGES-1:0] r3_edge;
    qlc_pkg::t_edge_t [qlc_pkg::EDGES-1:0] n3_edge;
    logic signed [qlc_pkg::PW-1:0] w_num [qlc_pkg::EDGES];
    logic signed [qlc_pkg::PW-1:0] w_den [qlc_pkg::EDGES];

    always_comb begin
        qlc_pkg::t_diff sx;
        qlc_pkg::t_diff sy;
        sx = qlc_pkg::t_diff'($signed(i_start.x));
        sy = qlc_pkg::t_diff'($signed(i_start.y));
        n1_seg.sx = i_start.x;
        n1_seg.sy = i_start.y;
        n1_seg.dx = qlc_pkg::t_diff'($signed(i_end.x)) - sx;
        n1_seg.dy = qlc_pkg::t_diff'($signed(i_end.y)) - sy;
        for (int e = 0; e < qlc_pkg::EDGES; e++) begin
            n1_nx[e] = qlc_pkg::t_diff'($signed(i_corner[e].y))
                     - qlc_pkg::t_diff'($signed(i_corner[(e + 1) % qlc_pkg::EDGES].y));
            n1_ny[e] = qlc_pkg::t_diff'($signed(i_corner[(e + 1) % qlc_pkg::EDGES].x))
                     - qlc_pkg::t_diff'($signed(i_corner[e].x));
            n1_ex[e] = qlc_pkg::t_diff'($signed(i_corner[e].x)) - sx;
            n1_ey[e] = qlc_pkg::t_diff'($signed(i_corner[e].y)) - sy;
        end
    end

    always_comb begin
        for (int e = 0; e < qlc_pkg::EDGES; e++) begin
            w_num[e] = qlc_pkg::PW'(r2_a[e]) + qlc_pkg::PW'(r2_b[e]);
            w_den[e] = qlc_pkg::PW'(r2_c[e]) + qlc_pkg::PW'(r2_d[e]);
            if (w_den[e] == '0) begin
                n3_edge[e].p   = qlc_pkg::TW'(w_num[e]);
                n3_edge[e].q   = qlc_pkg::TW'(1);
                n3_edge[e].ent = 1'b1;
            end else if (!w_den[e][qlc_pkg::PW-1]) begin
                n3_edge[e].p   = qlc_pkg::TW'(w_num[e]);
                n3_edge[e].q   = qlc_pkg::TW'(w_den[e]);
                n3_edge[e].ent = 1'b1;
            end else begin
                n3_edge[e].p   = qlc_pkg::TW'(0) - qlc_pkg::TW'(w_num[e]);
                n3_edge[e].q   = qlc_pkg::TW'(0) - qlc_pkg::TW'(w_den[e]);
                n3_edge[e].ent = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_seg  <= n1_seg;
            r2_seg  <= r1_seg;
            r3_seg  <= r2_seg;
            r3_edge <= n3_edge;
            for (int e = 0; e < qlc_pkg::EDGES; e++) begin
                r1_ex[e] <= n1_ex[e];
                r1_ey[e] <= n1_ey[e];
                r1_nx[e] <= n1_nx[e];
                r1_ny[e] <= n1_ny[e];
                r2_a[e]  <= r1_nx[e] * r1_ex[e];
                r2_b[e]  <= r1_ny[e] * r1_ey[e];
                r2_c[e]  <= r1_nx[e] * r1_seg.dx;
                r2_d[e]  <= r1_ny[e] * r1_seg.dy;
            end
        end
    end

    assign o_valid = r3_valid;
    assign o_seg   = r3_seg;
    assign o_edge  = r3_edge;

endmodule

@@ rtl/qlc_fold.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlc_fold
// Folds each edge fraction into t_enter and t_leave through a cross-product
// stage and a compare-and-select stage per edge, then the final reject test.
// ----------------------------------------------------------------------------
module qlc_fold (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  qlc_pkg::t_seg                         i_seg,
    input  qlc_pkg::t_edge_t [qlc_pkg::EDGES-1:0] i_edge,
    output logic                                  o_valid,
    output qlc_pkg::t_seg                         o_seg,
    output qlc_pkg::t_acc                         o_acc,
    output logic                                  o_vis
);

    logic                                  b_valid [qlc_pkg::EDGES+1];
    qlc_pkg::t_seg                         b_seg   [qlc_pkg::EDGES+1];
    qlc_pkg::t_acc                         b_acc   [qlc_pkg::EDGES+1];
    qlc_pkg::t_edge_t [qlc_pkg::EDGES-1:0] b_edge  [qlc_pkg::EDGES+1];

    assign b_valid[0] = i_valid;
    assign b_seg[0]   = i_seg;
    assign b_edge[0]  = i_edge;
    assign b_acc[0]   = '{ep: qlc_pkg::TW'(0), eq: qlc_pkg::TW'(1),
                          lp: qlc_pkg::TW'(1), lq: qlc_pkg::TW'(1)};

    for (genvar k = 0; k < qlc_pkg::EDGES; k++) begin : g_edge
        logic                                  r_mv;
        qlc_pkg::t_seg                         r_mseg;
        qlc_pkg::t_acc                         r_macc;
        qlc_pkg::t_edge_t [qlc_pkg::EDGES-1:0] r_medge;
        logic signed [qlc_pkg::XW-1:0]         r_x1;
        logic signed [qlc_pkg::XW-1:0]         r_x2;
        logic signed [qlc_pkg::XW-1:0]         n_x1;
        logic signed [qlc_pkg::XW-1:0]         n_x2;
        logic                                  r_v;
        qlc_pkg::t_seg                         r_seg;
        qlc_pkg::t_acc                         r_acc;
        qlc_pkg::t_edge_t [qlc_pkg::EDGES-1:0] r_edge;
        qlc_pkg::t_acc                         n_acc;

        always_comb begin
            qlc_pkg::t_frac p;
            qlc_pkg::t_frac q;
            qlc_pkg::t_frac rp;
            qlc_pkg::t_frac rq;
            p  = b_edge[k][k].p;
            q  = b_edge[k][k].q;
            rp = b_edge[k][k].ent ? b_acc[k].ep : b_acc[k].lp;
            rq = b_edge[k][k].ent ? b_acc[k].eq : b_acc[k].lq;
            n_x1 = p * rq;
            n_x2 = rp * q;
        end

        always_comb begin
            n_acc = r_macc;
            if (r_medge[k].ent) begin
                if (r_x1 > r_x2) begin
                    n_acc.ep = r_medge[k].p;
                    n_acc.eq = r_medge[k].q;
                end
            end else begin
                if (r_x1 < r_x2) begin
                    n_acc.lp = r_medge[k].p;
                    n_acc.lq = r_medge[k].q;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_mv <= 1'b0;
                r_v  <= 1'b0;
            end else if (i_en) begin
                r_mv <= b_valid[k];
                r_v  <= r_mv;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_mseg  <= b_seg[k];
                r_macc  <= b_acc[k];
                r_medge <= b_edge[k];
                r_x1    <= n_x1;
                r_x2    <= n_x2;
                r_seg   <= r_mseg;
                r_acc   <= n_acc;
                r_edge  <= r_medge;
            end
        end

        assign b_valid[k+1] = r_v;
        assign b_seg[k+1]   = r_seg;
        assign b_acc[k+1]   = r_acc;
        assign b_edge[k+1]  = r_edge;
    end

    logic                          r_fv;
    qlc_pkg::t_seg                 r_fseg;
    qlc_pkg::t_acc                 r_facc;
    logic signed [qlc_pkg::XW-1:0] r_f1;
    logic signed [qlc_pkg::XW-1:0] r_f2;
    logic signed [qlc_pkg::XW-1:0] n_f1;
    logic signed [qlc_pkg::XW-1:0] n_f2;
    logic                          r_ov;
    qlc_pkg::t_seg                 r_oseg;
    qlc_pkg::t_acc                 r_oacc;
    logic                          r_ovis;

    always_comb begin
        qlc_pkg::t_frac ep;
        qlc_pkg::t_frac eq;
        qlc_pkg::t_frac lp;
        qlc_pkg::t_frac lq;
        ep = b_acc[qlc_pkg::EDGES].ep;
        eq = b_acc[qlc_pkg::EDGES].eq;
        lp = b_acc[qlc_pkg::EDGES].lp;
        lq = b_acc[qlc_pkg::EDGES].lq;
        n_f1 = ep * lq;
        n_f2 = lp * eq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_fv <= b_valid[qlc_pkg::EDGES];
            r_ov <= r_fv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fseg <= b_seg[qlc_pkg::EDGES];
            r_facc <= b_acc[qlc_pkg::EDGES];
            r_f1   <= n_f1;
            r_f2   <= n_f2;
            r_oseg <= r_fseg;
            r_oacc <= r_facc;
            r_ovis <= !(r_f1 > r_f2);
        end
    end

    assign o_valid = r_ov;
    assign o_seg   = r_oseg;
    assign o_acc   = r_oacc;
    assign o_vis   = r_ovis;

    a_den_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_oacc.eq > 0) && (r_oacc.lq > 0))
        else $error("clip fraction denominator not positive");

endmodule

@@ rtl/qlc_interp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlc_interp
// Forms s*q + d*p for the four output coordinates and prepares the
// sign and magnitude for the divider.
// ----------------------------------------------------------------------------
module qlc_interp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  qlc_pkg::t_seg                         i_seg,
    input  qlc_pkg::t_acc                         i_acc,
    input  logic                                  i_vis,
    output logic                                  o_valid,
    output qlc_pkg::t_lane [qlc_pkg::COORDS-1:0]  o_lane,
    output logic                                  o_vis
);

    logic                          r1_valid;
    logic                          r1_vis;
    logic signed [qlc_pkg::NW-1:0] r1_sq [qlc_pkg::COORDS];
    logic signed [qlc_pkg::NW-1:0] r1_dp [qlc_pkg::COORDS];
    logic signed [qlc_pkg::NW-1:0] n1_sq [qlc_pkg::COORDS];
    logic signed [qlc_pkg::NW-1:0] n1_dp [qlc_pkg::COORDS];
    qlc_pkg::t_frac                r1_q  [qlc_pkg::COORDS];
    qlc_pkg::t_frac                n1_q  [qlc_pkg::COORDS];

    logic                          r2_valid;
    logic                          r2_vis;
    qlc_pkg::t_lane [qlc_pkg::COORDS-1:0] r2_lane;
    qlc_pkg::t_lane [qlc_pkg::COORDS-1:0] n2_lane;

    always_comb begin
        qlc_pkg::t_coord s;
        qlc_pkg::t_diff  d;
        qlc_pkg::t_frac  p;
        qlc_pkg::t_frac  q;
        for (int c = 0; c < qlc_pkg::COORDS; c++) begin
            s = (c % 2 == 0) ? i_seg.sx : i_seg.sy;
            d = (c % 2 == 0) ? i_seg.dx : i_seg.dy;
            p = (c < 2) ? i_acc.ep : i_acc.lp;
            q = (c < 2) ? i_acc.eq : i_acc.lq;
            n1_sq[c] = s * q;
            n1_dp[c] = d * p;
            n1_q[c]  = q;
        end
    end

    always_comb begin
        logic signed [qlc_pkg::NW-1:0] n;
        logic        [qlc_pkg::NW-1:0] mag;
        for (int c = 0; c < qlc_pkg::COORDS; c++) begin
            n   = r1_sq[c] + r1_dp[c];
            mag = n[qlc_pkg::NW-1] ? (qlc_pkg::NW'(0) - n) : n;
            n2_lane[c].rem = mag[qlc_pkg::NW-1:qlc_pkg::QB];
            n2_lane[c].nlo = mag[qlc_pkg::QB-1:0];
            n2_lane[c].quo = '0;
            n2_lane[c].q   = r1_q[c];
            n2_lane[c].neg = n[qlc_pkg::NW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_vis  <= i_vis;
            r2_vis  <= r1_vis;
            r2_lane <= n2_lane;
            for (int c = 0; c < qlc_pkg::COORDS; c++) begin
                r1_sq[c] <= n1_sq[c];
                r1_dp[c] <= n1_dp[c];
                r1_q[c]  <= n1_q[c];
            end
        end
    end

    assign o_valid = r2_valid;
    assign o_lane  = r2_lane;
    assign o_vis   = r2_vis;

endmodule

@@ rtl/qlc_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlc_div
// Pipelined restoring divider for the four coordinates, a fixed number of
// quotient bits per stage.
// ----------------------------------------------------------------------------
module qlc_div (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_en,
    input  logic                                  i_valid,
    input  qlc_pkg::t_lane [qlc_pkg::COORDS-1:0]  i_lane,
    input  logic                                  i_vis,
    output logic                                  o_valid,
    output qlc_pkg::t_lane [qlc_pkg::COORDS-1:0]  o_lane,
    output logic                                  o_vis
);

    logic                                 b_valid [qlc_pkg::DIV_STAGES+1];
    logic                                 b_vis   [qlc_pkg::DIV_STAGES+1];
    qlc_pkg::t_lane [qlc_pkg::COORDS-1:0] b_lane  [qlc_pkg::DIV_STAGES+1];

    assign b_valid[0] = i_valid;
    assign b_vis[0]   = i_vis;
    assign b_lane[0]  = i_lane;

    for (genvar k = 0; k < qlc_pkg::DIV_STAGES; k++) begin : g_stage
        logic                                 r_v;
        logic                                 r_vis;
        qlc_pkg::t_lane [qlc_pkg::COORDS-1:0] r_lane;
        qlc_pkg::t_lane [qlc_pkg::COORDS-1:0] n_lane;

        always_comb begin
            logic [qlc_pkg::RW:0] rem2;
            logic [qlc_pkg::RW:0] qx;
            logic                 ge;
            n_lane = b_lane[k];
            for (int c = 0; c < qlc_pkg::COORDS; c++) begin
                for (int s = 0; s < qlc_pkg::DIV_STEPS; s++) begin
                    if (k * qlc_pkg::DIV_STEPS + s < qlc_pkg::QB) begin
                        rem2 = {n_lane[c].rem, n_lane[c].nlo[qlc_pkg::QB-1]};
                        qx   = (qlc_pkg::RW + 1)'(n_lane[c].q);
                        ge   = (rem2 >= qx);
                        if (ge) begin
                            rem2 = rem2 - qx;
                        end
                        n_lane[c].rem = rem2[qlc_pkg::RW-1:0];
                        n_lane[c].nlo = {n_lane[c].nlo[qlc_pkg::QB-2:0], 1'b0};
                        n_lane[c].quo = {n_lane[c].quo[qlc_pkg::QB-2:0], ge};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= b_valid[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_vis  <= b_vis[k];
                r_lane <= n_lane;
            end
        end

        assign b_valid[k+1] = r_v;
        assign b_vis[k+1]   = r_vis;
        assign b_lane[k+1]  = r_lane;
    end

    assign o_valid = b_valid[qlc_pkg::DIV_STAGES];
    assign o_vis   = b_vis[qlc_pkg::DIV_STAGES];
    assign o_lane  = b_lane[qlc_pkg::DIV_STAGES];

    logic w_quo_ok;

    always_comb begin
        w_quo_ok = 1'b1;
        for (int c = 0; c < qlc_pkg::COORDS; c++) begin
            if (o_lane[c].quo > qlc_pkg::QUO_MAX) begin
                w_quo_ok = 1'b0;
            end
        end
    end

    a_quo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_vis) |-> w_quo_ok)
        else $error("clipped coordinate quotient out of range");

endmodule
